### design/mwcd_pkg.sv
`timescale 1ns / 1ps

package mwcd_pkg;

    localparam int NUM_CHANNELS_DEF = 6;
    localparam int SAMPLE_BITS_DEF  = 10;

    localparam int CODE_W     = 4;
    localparam int TOL_W      = 7;
    localparam int CNT_W      = 4;
    localparam int LEVEL_W    = 11;
    localparam int NUM_LEVELS = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef logic [CODE_W-1:0] class_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [TOL_W-1:0]  tol_t;

    localparam class_t CLASS_RED      = 4'd0;
    localparam class_t CLASS_BLUE     = 4'd1;
    localparam class_t CLASS_YELLOW   = 4'd2;
    localparam class_t CLASS_BLACK    = 4'd3;
    localparam class_t CLASS_WHITE    = 4'd4;
    localparam class_t CLASS_RED_BLUE = 4'd5;
    localparam class_t CLASS_OPEN     = 4'd6;
    localparam class_t CLASS_SHORT    = 4'd7;
    localparam class_t CLASS_INVALID  = 4'd8;

    localparam tol_t   TOL_RESET    = 7'd31;
    localparam count_t STABLE_RESET = 4'd3;

    localparam logic CMD_SCAN  = 1'b0;
    localparam logic CMD_REARM = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE    = 2'd0,
        CFG_STABLE_COUNT = 2'd1,
        CFG_SCAN_ENABLE  = 2'd2
    } cfg_idx_t;

    // per-lane result of one accepted scan
    typedef struct packed {
        logic   report;
        class_t code;
    } lane_stat_t;

    // nominal ADC level of each class, in table (priority) order
    function automatic logic [LEVEL_W-1:0] level_of(input class_t cls);
        logic [LEVEL_W-1:0] lvl;
        begin
            case (cls)
                CLASS_RED:      lvl = 11'd409;
                CLASS_BLUE:     lvl = 11'd614;
                CLASS_YELLOW:   lvl = 11'd205;
                CLASS_BLACK:    lvl = 11'd819;
                CLASS_WHITE:    lvl = 11'd717;
                CLASS_RED_BLUE: lvl = 11'd921;
                CLASS_OPEN:     lvl = 11'd1024;
                CLASS_SHORT:    lvl = 11'd0;
                default:        lvl = 11'd0;
            endcase
            return lvl;
        end
    endfunction

endpackage

### design/mwcd_lane.sv
`timescale 1ns / 1ps

module mwcd_lane #(
    parameter int SAMPLE_BITS = mwcd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   cmd,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  mwcd_pkg::tol_t         tolerance,
    input  mwcd_pkg::count_t       stable_count,
    input  logic                   scan_enable,
    output mwcd_pkg::lane_stat_t   stat
);
    import mwcd_pkg::*;

    localparam int CMP_W = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;

    class_t last_reg, last_next;
    count_t cnt_reg, cnt_next;
    class_t rep_reg, rep_next;

    logic [NUM_LEVELS-1:0] hit;
    logic [CMP_W-1:0]      v_ext;
    logic [CMP_W-1:0]      tol_ext;
    class_t                cls;
    logic                  report;

    assign v_ext   = CMP_W'(sample);
    assign tol_ext = CMP_W'(tolerance);

    // window compare, rearranged so nothing goes negative
    always_comb
    begin
        for (int c = 0; c < NUM_LEVELS; c++)
        begin
            hit[c] = (v_ext + tol_ext >= CMP_W'(level_of(CODE_W'(c))))
                  && (v_ext <= CMP_W'(level_of(CODE_W'(c))) + tol_ext);
        end
    end

    // first match in table order wins
    always_comb
    begin
        cls = CLASS_INVALID;
        for (int c = NUM_LEVELS - 1; c >= 0; c--)
        begin
            if (hit[c])
                cls = CODE_W'(c);
        end
    end

    always_comb
    begin
        last_next = last_reg;
        cnt_next  = cnt_reg;
        rep_next  = rep_reg;
        report    = 1'b0;
        if (accept)
        begin
            if (cmd == CMD_REARM)
                cnt_next = '0;
            else if (scan_enable)
            begin
                if (cls != last_reg)
                begin
                    last_next = cls;
                    cnt_next  = count_t'(1);
                end
                else if (cnt_reg < stable_count)
                begin
                    cnt_next = cnt_reg + count_t'(1);
                    if (cnt_next == stable_count)
                    begin
                        rep_next = last_reg;
                        report   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= CLASS_OPEN;
            cnt_reg  <= '0;
            rep_reg  <= CLASS_OPEN;
        end
        else
        begin
            last_reg <= last_next;
            cnt_reg  <= cnt_next;
            rep_reg  <= rep_next;
        end
    end

    assign stat.report = report;
    assign stat.code   = rep_next;

endmodule

### design/mwcd_merge.sv
`timescale 1ns / 1ps

module mwcd_merge #(
    parameter int NUM_CHANNELS = mwcd_pkg::NUM_CHANNELS_DEF,
    parameter int OUT_W        = ((NUM_CHANNELS * mwcd_pkg::CODE_W + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  mwcd_pkg::lane_stat_t stat [NUM_CHANNELS],
    output logic                 in_ready,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata
);
    import mwcd_pkg::*;

    typedef logic [NUM_CHANNELS-1:0][CODE_W-1:0] frame_t;

    frame_t     frame;
    logic       any_report;
    logic       push;
    logic       pop;

    // two-entry circular frame queue with read and write pointers
    frame_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        any_report = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            frame[i]   = stat[i].code;
            any_report = any_report | stat[i].report;
        end
    end

    assign push = accept & any_report;
    assign pop  = m_axis_tvalid & m_axis_tready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= frame;
    end

    assign in_ready      = (count_reg != 2'd2);
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = OUT_W'(mem[rd_ptr_reg]);

endmodule

### design/multilevel_wire_classifier_debounce_core.sv
`timescale 1ns / 1ps

// Wire classifier with debounce. Each request is either a scan (tuser 0) carrying one ADC
// sample per channel, or a rearm (tuser 1) that zeroes every debounce counter. Each
// channel lane window-compares its sample against eight fixed levels (plus or minus the
// tolerance register, first match wins, none gives code 8) and debounces the class; when
// any lane reaches stable_count the merge stage queues a frame of all reported codes.
// One request is accepted every cycle while the queue has room: lanes classify and update
// their counters in the accepting cycle, and the frame is written into a two-entry queue.
// tready drops only while both queue entries hold frames not yet taken downstream.
// Configuration (cfg_index 0 tolerance, 1 stable_count, 2 scan_enable) is always ready.
module multilevel_wire_classifier_debounce_core #(
    parameter int NUM_CHANNELS = mwcd_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = mwcd_pkg::SAMPLE_BITS_DEF,
    parameter int IN_W  = ((NUM_CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
    parameter int OUT_W = ((NUM_CHANNELS * mwcd_pkg::CODE_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,  // sample_0, sample_1, ... zero pad
    input  logic                          s_axis_tuser,  // cmd
    // stream out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_W-1:0]              m_axis_tdata,  // code_0, code_1, ... zero pad
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mwcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwcd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mwcd_pkg::*;

    tol_t   tol_reg, tol_next;
    count_t stable_reg, stable_next;
    logic   en_reg, en_next;

    logic       accept;
    lane_stat_t stat [NUM_CHANNELS];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tol_next    = tol_reg;
        stable_next = stable_reg;
        en_next     = en_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TOLERANCE:    tol_next    = cfg_data[TOL_W-1:0];
                CFG_STABLE_COUNT: stable_next = cfg_data[CNT_W-1:0];
                CFG_SCAN_ENABLE:  en_next     = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RESET;
            stable_reg <= STABLE_RESET;
            en_reg     <= 1'b1;
        end
        else
        begin
            tol_reg    <= tol_next;
            stable_reg <= stable_next;
            en_reg     <= en_next;
        end
    end

    assign accept = s_axis_tvalid & s_axis_tready;

    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_lane
        mwcd_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .accept       (accept),
            .cmd          (s_axis_tuser),
            .sample       (s_axis_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .tolerance    (tol_reg),
            .stable_count (stable_reg),
            .scan_enable  (en_reg),
            .stat         (stat[g])
        );
    end

    mwcd_merge #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .OUT_W        (OUT_W)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .stat          (stat),
        .in_ready      (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import mwcd_pkg::*;

    localparam int NCH     = 6;
    localparam int SBITS   = 10;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 24;
    localparam int FRAME_W = NCH * CODE_W;
    localparam int LIMIT   = 400000;
    localparam int QUIET   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef logic [FRAME_W-1:0]     frame_t;
    typedef logic [NCH*SBITS-1:0]   scan_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    tol_t   tol_q;
    count_t stable_q;
    logic   scan_en_q;
    class_t last_cls [NCH];
    count_t dcnt     [NCH];
    class_t rep_cls  [NCH];
    frame_t pending_frames [$];

    int cycles;
    int n_sent;
    int n_rearm;
    int n_frames;
    int n_cfg;
    int mismatches;
    int send_idle;
    int recv_idle;

    multilevel_wire_classifier_debounce_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d frames outstanding", cycles,
                     pending_frames.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic int nominal_level(input int c);
        case (c)
            0:       return 409;
            1:       return 614;
            2:       return 205;
            3:       return 819;
            4:       return 717;
            5:       return 921;
            6:       return 1024;
            default: return 0;
        endcase
    endfunction

    // first window in table order that holds the sample, else invalid
    function automatic class_t wire_class(input logic [SBITS-1:0] s, input tol_t tol);
        int lvl;
        for (int c = 0; c < NUM_LEVELS; c++)
        begin
            lvl = nominal_level(c);
            if (int'(s) >= lvl - int'(tol) && int'(s) <= lvl + int'(tol))
                return class_t'(c);
        end
        return CLASS_INVALID;
    endfunction

    task automatic classify_and_debounce(input logic cmd, input scan_t smp);
        class_t cls;
        logic   hit;
        frame_t fr;
        if (cmd == CMD_REARM)
        begin
            for (int i = 0; i < NCH; i++)
                dcnt[i] = '0;
            n_rearm++;
        end
        else if (scan_en_q)
        begin
            hit = 1'b0;
            for (int i = 0; i < NCH; i++)
            begin
                cls = wire_class(smp[i*SBITS +: SBITS], tol_q);
                if (cls != last_cls[i])
                begin
                    last_cls[i] = cls;
                    dcnt[i] = count_t'(1);
                end
                else if (dcnt[i] < stable_q)
                begin
                    dcnt[i] = dcnt[i] + count_t'(1);
                    if (dcnt[i] == stable_q)
                    begin
                        rep_cls[i] = last_cls[i];
                        hit = 1'b1;
                    end
                end
            end
            if (hit)
            begin
                for (int i = 0; i < NCH; i++)
                    fr[i*CODE_W +: CODE_W] = rep_cls[i];
                pending_frames.push_back(fr);
            end
        end
    endtask

    task automatic compare_frame(input logic [OUT_W-1:0] got);
        frame_t want;
        if (pending_frames.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected frame %h", $realtime, got);
        end
        else
        begin
            want = pending_frames.pop_front();
            n_frames++;
            for (int i = 0; i < NCH; i++)
            begin
                if (got[i*CODE_W +: CODE_W] !== want[i*CODE_W +: CODE_W])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: code_%0d expected %0d got %0d", $realtime, i,
                                 want[i*CODE_W +: CODE_W], got[i*CODE_W +: CODE_W]);
                end
            end
        end
    endtask

    // monitor: results first, then config, then the request taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                compare_frame(m_axis_tdata);
            if (cfg_valid && cfg_ready)
            begin
                n_cfg++;
                case (cfg_idx_t'(cfg_index))
                    CFG_TOLERANCE:    tol_q = cfg_data[TOL_W-1:0];
                    CFG_STABLE_COUNT: stable_q = cfg_data[CNT_W-1:0];
                    CFG_SCAN_ENABLE:  scan_en_q = cfg_data[0];
                    default:          ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                classify_and_debounce(s_axis_tuser, s_axis_tdata[NCH*SBITS-1:0]);
        end
    end

    task automatic send_req(input logic cmd, input scan_t smp);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_W'(smp);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_sent++;
        if (n_sent < 350)
        begin
            send_idle = 32;
            recv_idle = 63;
        end
        else if (n_sent < 700)
        begin
            send_idle = 63;
            recv_idle = 32;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        if ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
    endtask

    task automatic stream_stop;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_quiet;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (QUIET) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int tol, input int stab_raw, input int en);
        stream_stop();
        wait_quiet();
        cfg_write(CFG_TOLERANCE, CFG_DATA_W'(tol));
        cfg_write(CFG_STABLE_COUNT, CFG_DATA_W'(stab_raw));
        cfg_write(CFG_SCAN_ENABLE, CFG_DATA_W'(en));
    endtask

    function automatic scan_t pack_scan(input int s0, input int s1, input int s2,
                                        input int s3, input int s4, input int s5);
        return {SBITS'(s5), SBITS'(s4), SBITS'(s3), SBITS'(s2), SBITS'(s1), SBITS'(s0)};
    endfunction

    // sample around a class level: mostly inside the window, sometimes on or past its edge
    function automatic logic [SBITS-1:0] near_level(input int c, input int tol);
        int off;
        int v;
        int r;
        if (c >= NUM_LEVELS)
            return SBITS'($urandom_range(1023));
        r = $urandom_range(9);
        if (r == 0)
            off = tol + 1;
        else if (r == 1)
            off = tol;
        else
            off = $urandom_range(tol);
        if ($urandom_range(1))
            off = -off;
        v = nominal_level(c) + off;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return SBITS'(v);
    endfunction

    task automatic test_window_classes;
        scan_t a;
        scan_t b;
        a = pack_scan(409, 614, 205, 819, 717, 921);
        b = pack_scan(1023, 0, 378, 440, 377, 500);
        repeat (3) send_req(CMD_SCAN, a);
        repeat (3) send_req(CMD_SCAN, b);
    endtask

    // rearm keeps classes, clears counters; also works while scans are off
    task automatic test_rearm;
        scan_t a;
        scan_t b;
        a = pack_scan(409, 614, 205, 819, 717, 921);
        b = pack_scan(1023, 0, 378, 440, 377, 500);
        send_req(CMD_REARM, a);
        repeat (3) send_req(CMD_SCAN, b);
        set_config(31, 3, 0);
        send_req(CMD_SCAN, a);
        send_req(CMD_REARM, b);
        set_config(31, 3, 1);
    endtask

    // zero-width windows, then overlapping windows at the widest tolerance
    task automatic test_window_edges;
        set_config(0, 2, 1);
        repeat (2) send_req(CMD_SCAN, pack_scan(409, 410, 408, 1023, 0, 1));
        set_config(127, 2, 1);
        repeat (2) send_req(CMD_SCAN, pack_scan(500, 700, 330, 1023, 127, 800));
    endtask

    // spare register index ignored; stable count of one via masked write
    task automatic test_stable_one;
        stream_stop();
        wait_quiet();
        cfg_write(CFG_IDX_SPARE, 7'h55);
        cfg_write(CFG_STABLE_COUNT, 7'h71);
        send_req(CMD_REARM, '1);
        send_req(CMD_SCAN, pack_scan(500, 700, 330, 1023, 127, 800));
        send_req(CMD_SCAN, pack_scan(409, 614, 205, 819, 717, 921));
        send_req(CMD_SCAN, pack_scan(409, 614, 205, 819, 717, 921));
    endtask

    task automatic test_random(input int n, input int tol, input int stab_raw, input int en);
        int    hold_cls  [NCH];
        int    hold_left [NCH];
        int    stab;
        int    r;
        scan_t smp;
        stab = stab_raw & 15;
        for (int i = 0; i < NCH; i++)
            hold_left[i] = 0;
        set_config(tol, stab_raw, en);
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            for (int i = 0; i < NCH; i++)
                smp[i*SBITS +: SBITS] = SBITS'($urandom_range(1023));
            if (r < 3)
                send_req(CMD_REARM, smp);
            else if (r < 13)
                send_req(CMD_SCAN, smp);
            else
            begin
                for (int i = 0; i < NCH; i++)
                begin
                    if (hold_left[i] == 0)
                    begin
                        hold_cls[i]  = $urandom_range(NUM_LEVELS);
                        hold_left[i] = $urandom_range(stab + 3, 1);
                    end
                    hold_left[i]--;
                    smp[i*SBITS +: SBITS] = near_level(hold_cls[i], tol);
                end
                send_req(CMD_SCAN, smp);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_SCAN;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tol_q         = TOL_RESET;
        stable_q      = STABLE_RESET;
        scan_en_q     = 1'b1;
        for (int i = 0; i < NCH; i++)
        begin
            last_cls[i] = CLASS_OPEN;
            dcnt[i]     = '0;
            rep_cls[i]  = CLASS_OPEN;
        end
        cycles     = 0;
        n_sent     = 0;
        n_rearm    = 0;
        n_frames   = 0;
        n_cfg      = 0;
        mismatches = 0;
        send_idle  = 32;
        recv_idle  = 63;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_window_classes();
        test_rearm();
        test_window_edges();
        test_stable_one();
        test_random(200, 31, 3, 1);
        test_random(150, 0, 2, 1);
        test_random(200, 127, 7'h7F, 1);
        test_random(100, 64, 1, 1);
        test_random(80, 20, 7'h50, 1);
        test_random(60, 40, 4, 0);
        test_random(260, 90, 7, 1);

        stream_stop();
        wait_quiet();
        repeat (8) @(posedge clk);

        if (pending_frames.size() != 0)
        begin
            $display("%0d expected frames never arrived", pending_frames.size());
            mismatches += pending_frames.size();
        end
        $display("%0d requests (%0d rearm), %0d frames checked, %0d config writes, %0d errors",
                 n_sent, n_rearm, n_frames, n_cfg, mismatches);
        $display("tolerance 0..127, stable count 0..15, scans off and on, three stall mixes");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### multilevel_wire_classifier_debounce_core.f
design/mwcd_pkg.sv
design/mwcd_lane.sv
design/mwcd_merge.sv
design/multilevel_wire_classifier_debounce_core.sv
verif/tb.sv
